// ----- hw/rtl/pidis_pkg.sv -----
// shared types and constants for the pid integral separation unit
`timescale 1ns / 1ps
package pidis_pkg;

    localparam int ERR_W   = 17;
    localparam int DERR_W  = 18;
    localparam int PROD_W  = 34;
    localparam int DPROD_W = 35;
    localparam int INTEG_W = 40;
    localparam int SUM_W   = 42;
    localparam int FRAC_W  = 8;
    localparam int RES_W   = SUM_W - FRAC_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [14:0] OUT_LIMIT_RST = 15'h7fff;

    // largest integral magnitude, one bit wider than the integral for compares
    localparam logic signed [INTEG_W:0] INTEG_MAX = 41'sh007f_ffff_ffff;

    typedef enum logic [2:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_OUTPUT_LIMIT   = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_INTEGRAL_BAND  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [14:0] output_limit;
        logic [22:0] integral_limit;
        logic [16:0] integral_band;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
        logic                     clear;
    } cmd_t;

endpackage

// ----- hw/rtl/pidis_cfg.sv -----
// configuration register file with apb-style access
`timescale 1ns / 1ps
module pidis_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidis_pkg::ADDR_W-1:0] paddr,
    input  logic [pidis_pkg::DATA_W-1:0] pwdata,
    output logic [pidis_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output pidis_pkg::cfg_t              cfg
);
    import pidis_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GAIN_P:         cfg_next.gain_p         = pwdata[15:0];
                REG_GAIN_I:         cfg_next.gain_i         = pwdata[15:0];
                REG_GAIN_D:         cfg_next.gain_d         = pwdata[15:0];
                REG_OUTPUT_LIMIT:   cfg_next.output_limit   = pwdata[14:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = pwdata[22:0];
                REG_INTEGRAL_BAND:  cfg_next.integral_band  = pwdata[16:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAIN_P:         prdata = {16'd0, cfg_reg.gain_p};
            REG_GAIN_I:         prdata = {16'd0, cfg_reg.gain_i};
            REG_GAIN_D:         prdata = {16'd0, cfg_reg.gain_d};
            REG_OUTPUT_LIMIT:   prdata = {17'd0, cfg_reg.output_limit};
            REG_INTEGRAL_LIMIT: prdata = {9'd0, cfg_reg.integral_limit};
            REG_INTEGRAL_BAND:  prdata = {15'd0, cfg_reg.integral_band};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_limit   <= OUT_LIMIT_RST;
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_limit <= '0;
            cfg_reg.integral_band  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/pidis_front.sv -----
// front end: forms the error, its difference and the integral separation decision
`timescale 1ns / 1ps
module pidis_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pidis_pkg::cfg_t            cfg,
    input  logic                       push,
    input  logic signed [15:0]         target_value,
    input  logic signed [15:0]         measured_value,
    input  logic                       q_full,
    output logic                       q_push,
    output pidis_pkg::cmd_t            q_data
);
    import pidis_pkg::*;

    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ERR_W-1:0] prev_err_next;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        mag;

    assign err    = ERR_W'(target_value) - ERR_W'(measured_value);
    assign mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign q_push = push && !q_full;

    always_comb
    begin
        q_data.err   = err;
        q_data.derr  = DERR_W'(err) - DERR_W'(prev_err_reg);
        // band reached or passed: integral gets cleared, unless the band is zero
        q_data.clear = (cfg.integral_band != '0) && (mag >= cfg.integral_band);
        prev_err_next = q_push ? err : prev_err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else
        begin
            prev_err_reg <= prev_err_next;
        end
    end

endmodule

// ----- hw/rtl/pidis_cmd_q.sv -----
// short queue between the front end and the back end
`timescale 1ns / 1ps
module pidis_cmd_q (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pidis_pkg::cmd_t wdata,
    output logic            full,
    input  logic            pop,
    output pidis_pkg::cmd_t rdata,
    output logic            empty
);
    import pidis_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/pidis_back.sv -----
// back end: products, integral update, sum and output clamp, with result queue
`timescale 1ns / 1ps
module pidis_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pidis_pkg::cfg_t    cfg,
    input  pidis_pkg::cmd_t    cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic signed [15:0] control_out,
    output logic               out_clamped,
    output logic               empty,
    input  logic               pop
);
    import pidis_pkg::*;

    // stage 1: products
    logic                       s1_valid_reg;
    logic                       s1_clear_reg;
    logic signed [PROD_W-1:0]   s1_p_reg;
    logic signed [PROD_W-1:0]   s1_i_reg;
    logic signed [DPROD_W-1:0]  s1_d_reg;
    // stage 2: integral state and the other two terms
    logic                       s2_valid_reg;
    logic signed [PROD_W-1:0]   s2_p_reg;
    logic signed [DPROD_W-1:0]  s2_d_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [INTEG_W-1:0]  integ_next;
    // stage 3: full sum
    logic                       s3_valid_reg;
    logic signed [SUM_W-1:0]    s3_sum_reg;

    logic                       advance;
    logic signed [INTEG_W:0]    acc;
    logic signed [INTEG_W:0]    bound;
    logic signed [INTEG_W:0]    acc_lim;
    logic signed [RES_W-1:0]    res;
    logic signed [RES_W-1:0]    lim;
    logic signed [15:0]         res_out;
    logic                       res_clamped;

    // result queue
    logic signed [15:0]         oq_val_reg [Q_DEPTH];
    logic                       oq_clp_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]         oq_wr_reg;
    logic [Q_PTR_W-1:0]         oq_rd_reg;
    logic [Q_PTR_W:0]           oq_cnt_reg;
    logic [Q_PTR_W:0]           oq_cnt_next;
    logic                       oq_full;
    logic                       oq_push;
    logic                       oq_pop;

    assign oq_full = (oq_cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty   = (oq_cnt_reg == '0);
    assign oq_pop  = pop && !empty;
    assign advance = !s3_valid_reg || !oq_full;
    assign oq_push = s3_valid_reg && !oq_full;
    assign cmd_pop = advance && !cmd_empty;

    assign control_out = oq_val_reg[oq_rd_reg];
    assign out_clamped = oq_clp_reg[oq_rd_reg];

    // integral update: one add, then a single clamp to the tighter bound
    always_comb
    begin
        acc   = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(s1_i_reg);
        bound = (cfg.integral_limit != '0) ?
                $signed({10'd0, cfg.integral_limit, 8'd0}) : INTEG_MAX;
        if (acc > bound)
        begin
            acc_lim = bound;
        end
        else if (acc < -bound)
        begin
            acc_lim = -bound;
        end
        else
        begin
            acc_lim = acc;
        end
        integ_next = integ_reg;
        if (advance && s1_valid_reg)
        begin
            integ_next = s1_clear_reg ? '0 : acc_lim[INTEG_W-1:0];
        end
    end

    // floor shift then output clamp
    always_comb
    begin
        res         = s3_sum_reg[SUM_W-1:FRAC_W];
        lim         = $signed({(RES_W-15)'(0), cfg.output_limit});
        res_out     = res[15:0];
        res_clamped = 1'b0;
        if (res > lim)
        begin
            res_out     = lim[15:0];
            res_clamped = 1'b1;
        end
        else if (res < -lim)
        begin
            res_out     = 16'(-lim);
            res_clamped = 1'b1;
        end
    end

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (oq_push && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (oq_pop && !oq_push)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_clear_reg <= cmd.clear;
            s1_p_reg     <= $signed({1'b0, cfg.gain_p}) * cmd.err;
            s1_i_reg     <= $signed({1'b0, cfg.gain_i}) * cmd.err;
            s1_d_reg     <= $signed({1'b0, cfg.gain_d}) * cmd.derr;
            s2_p_reg     <= s1_p_reg;
            s2_d_reg     <= s1_d_reg;
            s3_sum_reg   <= SUM_W'(s2_p_reg) + SUM_W'(integ_reg) + SUM_W'(s2_d_reg);
        end
        if (oq_push)
        begin
            oq_val_reg[oq_wr_reg] <= res_out;
            oq_clp_reg[oq_wr_reg] <= res_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            integ_reg    <= '0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_cnt_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= !cmd_empty;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            integ_reg  <= integ_next;
            oq_wr_reg  <= oq_push ? oq_wr_reg + 1'b1 : oq_wr_reg;
            oq_rd_reg  <= oq_pop ? oq_rd_reg + 1'b1 : oq_rd_reg;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

`ifndef SYNTHESIS
    // integral never reaches the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg != $signed({1'b1, (INTEG_W-1)'(0)}))
    else $error("integral left its saturation range");

    // a separated request leaves a cleared integral
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && s1_clear_reg) |=> (integ_reg == '0))
    else $error("integral not cleared on separation");

    // bubbles do not disturb the integral
    assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg) |=> $stable(integ_reg))
    else $error("integral changed without a request");

    // result queue count stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("result queue overrun");
`endif

endmodule

// ----- hw/rtl/pid_integral_separation_unit.sv -----
// top level of the pid unit with integral separation and clamps
`timescale 1ns / 1ps
// Positional PID with integral separation, integral clamp and output clamp.
// Requests enter like a queue write: target_value and measured_value are
// taken at a clock edge with push high and full low. Results leave like a
// queue read: control_out and out_clamped show the oldest result while empty
// is low, and pop at such an edge takes it. One result per request, in order.
// Gains and limits are set through the apb-style port (4-byte registers:
// gain_p, gain_i, gain_d, output_limit, integral_limit, integral_band). The
// user must set them only while no request is in flight; nothing enforces it.
// Throughput is one request per cycle while the result queue has room: the
// front end and the three-stage back end (products, integral update, sum)
// each take a request every cycle; the integral update loop sets this rate.
// A request passes the front queue and stages 1 to 3; then empty drops.
// A 4-entry queue sits between front and back end and another holds
// results; when pop stays low the back end stops once the result queue is
// full, then the front queue fills and full rises.
// Reset empties both queues, clears integral and previous error, sets the
// gains and integral limit and band to zero and output_limit to 32767.
module pid_integral_separation_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidis_pkg::ADDR_W-1:0] paddr,
    input  logic [pidis_pkg::DATA_W-1:0] pwdata,
    output logic [pidis_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic signed [15:0]           target_value,
    input  logic signed [15:0]           measured_value,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [15:0]           control_out,
    output logic                         out_clamped
);
    import pidis_pkg::*;

    cfg_t cfg;
    cmd_t q_wdata;
    cmd_t q_rdata;
    logic q_push;
    logic q_pop;
    logic q_empty;

    pidis_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidis_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .push           (push),
        .target_value   (target_value),
        .measured_value (measured_value),
        .q_full         (full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    pidis_cmd_q u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    pidis_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (q_rdata),
        .cmd_empty   (q_empty),
        .cmd_pop     (q_pop),
        .control_out (control_out),
        .out_clamped (out_clamped),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ----- dv/tb_pid_integral_separation_unit.sv -----
`timescale 1ns / 1ps
// testbench for the pid integral separation unit: directed and random requests against a predictor
module tb_pid_integral_separation_unit;
    import pidis_pkg::*;

    localparam int         PIPE_LAT    = 4;
    localparam int         HOLD_CYCLES = 80;
    localparam int         PHASE_ITEMS = 40;
    localparam logic [2:0] REG_NONE    = 3'd6;
    localparam longint     INTEG_SAT   = 64'sd549755813887;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_e;

    typedef struct {
        row_kind_e          kind;
        logic [2:0]         sel;
        logic [31:0]        wdata;
        logic signed [15:0] tgt;
        logic signed [15:0] meas;
        bit                 known;
        logic signed [15:0] out;
        logic               clamp;
    } stim_row_t;

    typedef struct {
        logic signed [15:0] out;
        logic               clamp;
    } ctrl_result_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                push           = 1'b0;
    logic                full;
    logic signed [15:0]  target_value   = '0;
    logic signed [15:0]  measured_value = '0;
    logic                empty;
    logic                pop            = 1'b0;
    logic signed [15:0]  control_out;
    logic                out_clamped;

    // directed rows with a result known up front ride along with the request
    bit                  row_known   = 1'b0;
    logic signed [15:0]  known_out   = '0;
    logic                known_clamp = 1'b0;

    bit                  steady   = 1'b0;
    bit                  hold_arm = 1'b0;
    int                  hold_left = 0;
    int                  fail_cnt  = 0;

    // shadow of the registers and of the loop state
    cfg_t                loop_cfg  = {48'h0, OUT_LIMIT_RST, 40'h0};
    longint              integ_acc = 0;
    int                  prev_err  = 0;
    ctrl_result_t        ctrl_expect_q[$];

    pid_integral_separation_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .target_value   (target_value),
        .measured_value (measured_value),
        .empty          (empty),
        .pop            (pop),
        .control_out    (control_out),
        .out_clamped    (out_clamped)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic ctrl_result_t predict_control(input logic signed [15:0] tgt, meas);
        ctrl_result_t r;
        int           err;
        int           mag;
        longint       lim_i;
        longint       res;
        err = int'(tgt) - int'(meas);
        mag = (err < 0) ? -err : err;
        // integral separation: large errors wipe the integral
        if (loop_cfg.integral_band != 0 && mag >= int'(loop_cfg.integral_band))
            integ_acc = 0;
        else
        begin
            integ_acc += longint'(loop_cfg.gain_i) * err;
            if (integ_acc > INTEG_SAT)
                integ_acc = INTEG_SAT;
            else if (integ_acc < -INTEG_SAT)
                integ_acc = -INTEG_SAT;
        end
        if (loop_cfg.integral_limit != 0)
        begin
            lim_i = longint'(loop_cfg.integral_limit) <<< FRAC_W;
            if (integ_acc > lim_i)
                integ_acc = lim_i;
            else if (integ_acc < -lim_i)
                integ_acc = -lim_i;
        end
        res = (longint'(loop_cfg.gain_p) * err + integ_acc
               + longint'(loop_cfg.gain_d) * (err - prev_err)) >>> FRAC_W;
        r.clamp = 1'b0;
        if (res > longint'(loop_cfg.output_limit))
        begin
            res     = longint'(loop_cfg.output_limit);
            r.clamp = 1'b1;
        end
        else if (res < -longint'(loop_cfg.output_limit))
        begin
            res     = -longint'(loop_cfg.output_limit);
            r.clamp = 1'b1;
        end
        prev_err = err;
        r.out    = 16'(res);
        return r;
    endfunction

    // request and result bookkeeping, sampled at the edge
    always @(posedge clk)
    begin
        ctrl_result_t model_r;
        ctrl_result_t head_r;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_GAIN_P:         loop_cfg.gain_p         = pwdata[15:0];
                    REG_GAIN_I:         loop_cfg.gain_i         = pwdata[15:0];
                    REG_GAIN_D:         loop_cfg.gain_d         = pwdata[15:0];
                    REG_OUTPUT_LIMIT:   loop_cfg.output_limit   = pwdata[14:0];
                    REG_INTEGRAL_LIMIT: loop_cfg.integral_limit = pwdata[22:0];
                    REG_INTEGRAL_BAND:  loop_cfg.integral_band  = pwdata[16:0];
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                model_r = predict_control(target_value, measured_value);
                if (row_known)
                begin
                    model_r.out   = known_out;
                    model_r.clamp = known_clamp;
                end
                ctrl_expect_q.push_back(model_r);
            end
            if (pop && !empty)
            begin
                if (ctrl_expect_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected control result %0d/%0b with no request pending",
                                 control_out, out_clamped);
                end
                else
                begin
                    head_r = ctrl_expect_q.pop_front();
                    if (head_r.out !== control_out || head_r.clamp !== out_clamped)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("control result mismatch: expected %0d/%0b, got %0d/%0b",
                                     head_r.out, head_r.clamp, control_out, out_clamped);
                    end
                end
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_arm)
            begin
                hold_arm  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    function automatic stim_row_t row_write(input logic [2:0] sel, input logic [31:0] wdata);
        stim_row_t r;
        r.kind  = ROW_WRITE;
        r.sel   = sel;
        r.wdata = wdata;
        r.tgt   = '0;
        r.meas  = '0;
        r.known = 1'b0;
        r.out   = '0;
        r.clamp = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t row_sample(input logic signed [15:0] tgt, meas,
                                             input bit known = 1'b0,
                                             input logic signed [15:0] out = '0,
                                             input logic clamp = 1'b0);
        stim_row_t r;
        r.kind  = ROW_SAMPLE;
        r.sel   = '0;
        r.wdata = '0;
        r.tgt   = tgt;
        r.meas  = meas;
        r.known = known;
        r.out   = out;
        r.clamp = clamp;
        return r;
    endfunction

    function automatic logic [31:0] pick_cfg(input logic [2:0] sel);
        logic [31:0] mask;
        logic [31:0] v;
        int          cap;
        case (sel)
            REG_GAIN_P, REG_GAIN_I, REG_GAIN_D:
            begin
                mask = 32'h0000_ffff;
                cap  = 768;
            end
            REG_OUTPUT_LIMIT:
            begin
                mask = 32'h0000_7fff;
                cap  = 2000;
            end
            REG_INTEGRAL_LIMIT:
            begin
                mask = 32'h007f_ffff;
                cap  = 3000;
            end
            default:
            begin
                mask = 32'h0001_ffff;
                cap  = 400;
            end
        endcase
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = mask;
            2, 3:    v = $urandom & mask;
            default: v = $urandom_range(1, cap);
        endcase
        // junk above the register width must be dropped
        if ($urandom_range(0, 3) == 0)
            v |= $urandom & ~mask;
        return v;
    endfunction

    function automatic logic signed [15:0] pick_val();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3, 4:    return 16'($urandom_range(0, 400)) - 16'sd200;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [15:0] tgt, meas,
                               input bit known = 1'b0,
                               input logic signed [15:0] kout = '0,
                               input logic kclamp = 1'b0);
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        target_value   <= tgt;
        measured_value <= meas;
        row_known      <= known;
        known_out      <= kout;
        known_clamp    <= kclamp;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (ctrl_expect_q.size() != 0);
    endtask

    task automatic apb_write(input logic [2:0] sel, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        stim_row_t          directed_rows[$];
        reg_idx_t           ri;
        logic signed [15:0] t;
        logic signed [15:0] m;
        int                 near;
        bit                 neg;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all gains zero after reset
        directed_rows.push_back(row_sample(16'sh7fff, 16'sh8000, 1'b1, 16'sd0, 1'b0));
        directed_rows.push_back(row_sample(16'sh8000, 16'sh7fff, 1'b1, 16'sd0, 1'b0));
        // unity proportional gain, output clamp at both ends
        directed_rows.push_back(row_write(REG_GAIN_P, 32'd256));
        directed_rows.push_back(row_sample(16'sd100, 16'sd40, 1'b1, 16'sd60, 1'b0));
        directed_rows.push_back(row_sample(16'sh7fff, 16'sh8000, 1'b1, 16'sd32767, 1'b1));
        directed_rows.push_back(row_sample(16'sh8000, 16'sh7fff, 1'b1, -16'sd32767, 1'b1));
        // zero output limit flags every nonzero sum
        directed_rows.push_back(row_write(REG_OUTPUT_LIMIT, 32'd0));
        directed_rows.push_back(row_sample(16'sd5, 16'sd0, 1'b1, 16'sd0, 1'b1));
        directed_rows.push_back(row_sample(16'sd0, 16'sd3, 1'b1, 16'sd0, 1'b1));
        directed_rows.push_back(row_sample(16'sd0, 16'sd0, 1'b1, 16'sd0, 1'b0));
        directed_rows.push_back(row_write(REG_OUTPUT_LIMIT, 32'hffff_ffff));
        // half gain: floor rounding of the shifted sum
        directed_rows.push_back(row_write(REG_GAIN_P, 32'd128));
        directed_rows.push_back(row_sample(16'sd0, 16'sd1, 1'b1, -16'sd1, 1'b0));
        directed_rows.push_back(row_sample(16'sd1, 16'sd0, 1'b1, 16'sd0, 1'b0));
        // full gains, separation band edges
        directed_rows.push_back(row_write(REG_GAIN_I, 32'h0000_ffff));
        directed_rows.push_back(row_write(REG_GAIN_D, 32'h0000_ffff));
        directed_rows.push_back(row_write(REG_GAIN_P, 32'h0000_ffff));
        directed_rows.push_back(row_write(REG_INTEGRAL_BAND, 32'd100));
        directed_rows.push_back(row_sample(16'sd100, 16'sd0));
        directed_rows.push_back(row_sample(16'sd99, 16'sd0));
        directed_rows.push_back(row_sample(-16'sd99, 16'sd0));
        directed_rows.push_back(row_sample(16'sd0, 16'sd100));
        // tightest integral clamp
        directed_rows.push_back(row_write(REG_INTEGRAL_LIMIT, 32'd1));
        directed_rows.push_back(row_sample(16'sd50, 16'sd0));
        directed_rows.push_back(row_sample(-16'sd50, 16'sd0));
        // write to an unused register must change nothing
        directed_rows.push_back(row_write(REG_NONE, 32'hffff_ffff));
        directed_rows.push_back(row_sample(16'sd7, -16'sd7));
        directed_rows.push_back(row_write(REG_INTEGRAL_LIMIT, 32'h007f_ffff));
        directed_rows.push_back(row_write(REG_INTEGRAL_BAND, 32'h0001_ffff));
        directed_rows.push_back(row_sample(16'sh7fff, 16'sh8000));
        directed_rows.push_back(row_sample(16'sh8000, 16'sh7fff));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_results();
                apb_write(directed_rows[i].sel, directed_rows[i].wdata);
            end
            else
                send_sample(directed_rows[i].tgt, directed_rows[i].meas, directed_rows[i].known,
                            directed_rows[i].out, directed_rows[i].clamp);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            steady = (ph == 3);
            ri = ri.first();
            do
            begin
                apb_write(ri, pick_cfg(ri));
                ri = ri.next();
            end
            while (ri != ri.first());
            if (ph % 2 == 1)
                apb_write(REG_NONE, $urandom);
            // stall the result side so the input queue backs up
            if (ph == 1)
                hold_arm = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                t = pick_val();
                case ($urandom_range(0, 3))
                    0:
                    begin
                        // errors right around the separation band
                        near = int'(t) - (($urandom_range(0, 1) == 0) ? 1 : -1)
                               * (int'(loop_cfg.integral_band) + int'($urandom_range(0, 2)) - 1);
                        m = (near >= -32768 && near <= 32767) ? 16'(near) : pick_val();
                    end
                    1:       m = t + 16'(int'($urandom_range(0, 20)) - 10);
                    default: m = pick_val();
                endcase
                send_sample(t, m);
            end
        end

        // integral windup with no limit and no band until the integral saturates
        drain_results();
        steady = 1'b0;
        apb_write(REG_GAIN_P, pick_cfg(REG_GAIN_P));
        apb_write(REG_GAIN_I, 32'h0000_ffff);
        apb_write(REG_GAIN_D, pick_cfg(REG_GAIN_D));
        apb_write(REG_OUTPUT_LIMIT, pick_cfg(REG_OUTPUT_LIMIT));
        apb_write(REG_INTEGRAL_LIMIT, 32'd0);
        apb_write(REG_INTEGRAL_BAND, 32'd0);
        neg = 1'($urandom_range(0, 1));
        repeat (160)
        begin
            t = 16'sh7fff - 16'($urandom_range(0, 1500));
            m = 16'sh8000 + 16'($urandom_range(0, 1500));
            if (neg)
                send_sample(m, t);
            else
                send_sample(t, m);
        end

        drain_results();
        repeat (4 * PIPE_LAT) @(posedge clk);
        fail_cnt += ctrl_expect_q.size();
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- pid_integral_separation_unit.f -----
hw/rtl/pidis_pkg.sv
hw/rtl/pidis_cfg.sv
hw/rtl/pidis_front.sv
hw/rtl/pidis_cmd_q.sv
hw/rtl/pidis_back.sv
hw/rtl/pid_integral_separation_unit.sv
dv/tb_pid_integral_separation_unit.sv
